FILE: src/assert_macros.svh
// Assertion macros shared by the lane edge scanner modules.
// Expects signals named clk and rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/lers_pkg.sv
// Shared types, constants and helpers for the lane edge row scanner.
// Used by lers_front, lers_queue, lers_back and lane_edge_row_scanner.
package lers_pkg;

  localparam int COL_BITS       = 12;
  localparam int TOTAL_BITS     = 32;
  localparam int DIM_BITS       = COL_BITS + 1;
  localparam int CFG_BITS       = 13;
  localparam int CFG_IDX_BITS   = 3;
  localparam int FIELD_COL_BITS = 12;
  localparam int FIELD_CNT_BITS = 13;
  localparam int MODE_BITS      = 2;
  localparam int S_TDATA_BITS   = 8;
  localparam int M_TDATA_BITS   = 80;
  localparam int RESULT_BITS    = 4 * FIELD_COL_BITS + 2 + MODE_BITS + 2 * FIELD_CNT_BITS;
  localparam int RESULT_PAD     = M_TDATA_BITS - RESULT_BITS;

  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS  = FIFO_PTR_BITS + 1;

  localparam int RANGE_BITS     = COL_BITS - 1;
  localparam int RANGE10_BITS   = COL_BITS + 2;
  localparam int DVS_BITS       = TOTAL_BITS + 5;
  localparam int PROD_BITS      = RANGE10_BITS + TOTAL_BITS;
  localparam int REM_BITS       = DVS_BITS + COL_BITS - 1;
  localparam int DIV_CNT_BITS   = $clog2(COL_BITS);

  localparam logic [FIELD_CNT_BITS-1:0] CNT_MAX = '1;

  localparam logic [CFG_BITS-1:0]       RST_FRAME_WIDTH    = CFG_BITS'(1280);
  localparam logic [CFG_BITS-1:0]       RST_FRAME_HEIGHT   = CFG_BITS'(720);
  localparam logic [FIELD_COL_BITS-1:0] RST_BAND_FIRST_ROW = FIELD_COL_BITS'(360);
  localparam logic [CFG_BITS-1:0]       RST_BAND_END_ROW   = CFG_BITS'(647);
  localparam logic [CFG_BITS-1:0]       RST_MIN_EDGE_ROWS  = CFG_BITS'(10);
  localparam logic [COL_BITS-1:0]       RST_CENTER         = COL_BITS'(640);

  localparam logic KIND_ROW     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [MODE_BITS-1:0] MODE_NONE  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_BOTH  = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_RIGHT = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_LEFT  = 2'd3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FRAME_WIDTH,
    CFG_FRAME_HEIGHT,
    CFG_BAND_FIRST_ROW,
    CFG_BAND_END_ROW,
    CFG_MIN_EDGE_ROWS
  } cfg_index_t;

  typedef struct packed {
    logic [CFG_BITS-1:0]       frame_width;
    logic [CFG_BITS-1:0]       frame_height;
    logic [FIELD_COL_BITS-1:0] band_first_row;
    logic [CFG_BITS-1:0]       band_end_row;
    logic [CFG_BITS-1:0]       min_edge_rows;
  } lers_cfg_t;

  typedef struct packed {
    logic                      has_row;
    logic                      frame_end;
    logic [COL_BITS-1:0]       row_index;
    logic                      left_found;
    logic [COL_BITS-1:0]       left_col;
    logic                      right_found;
    logic [COL_BITS-1:0]       right_col;
    logic [FIELD_CNT_BITS-1:0] left_rows;
    logic [FIELD_CNT_BITS-1:0] right_rows;
  } lers_event_t;

  typedef struct packed {
    logic                update;
    logic [COL_BITS-1:0] col;
  } lers_center_t;

  typedef struct packed {
    logic [RESULT_PAD-1:0]     pad;
    logic [FIELD_CNT_BITS-1:0] right_rows;
    logic [FIELD_CNT_BITS-1:0] left_rows;
    logic [MODE_BITS-1:0]      lane_mode;
    logic [FIELD_COL_BITS-1:0] center_col;
    logic [FIELD_COL_BITS-1:0] right_col;
    logic                      right_found;
    logic [FIELD_COL_BITS-1:0] left_col;
    logic                      left_found;
    logic [FIELD_COL_BITS-1:0] row_index;
  } lers_result_t;

  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [CFG_BITS-1:0] v);
    logic [31:0] v32;
    v32 = 32'(v);
    if (v32 == 32'd0) begin
      return DIM_BITS'(1);
    end else if (v32 > (32'd1 << COL_BITS)) begin
      return DIM_BITS'(32'd1 << COL_BITS);
    end else begin
      return v32[DIM_BITS-1:0];
    end
  endfunction

  function automatic logic [FIELD_COL_BITS-1:0] to_field_col(input logic [COL_BITS-1:0] v);
    logic [31:0] v32;
    v32 = 32'(v);
    return v32[FIELD_COL_BITS-1:0];
  endfunction

endpackage

FILE: src/lane_edge_row_scanner.sv
// Throughput: one pixel per cycle while the event queue has room; after a frame end the
// input stalls until the back end publishes the new center, longer while a row result
// waits. Reset (rst, synchronous): registers to defaults, center 640, totals one, queue
// empty. Depends on lers_pkg, lers_front, lers_queue, lers_back.
module lane_edge_row_scanner (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [lers_pkg::S_TDATA_BITS-1:0]   s_axis_tdata,  // [0] pixel_on, rest zero
  input  logic                                s_axis_tuser,  // [0] frame_begin
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [11:0] row_index, [12] left_found, [24:13] left_col, [25] right_found,
  // [37:26] right_col, [49:38] center_col, [51:50] lane_mode,
  // [64:52] left_rows, [77:65] right_rows, [79:78] zero
  output logic [lers_pkg::M_TDATA_BITS-1:0]   m_axis_tdata,
  output logic                                m_axis_tuser,  // [0] result_kind
  output logic                                m_axis_tlast,
  input  logic                                cfg_wr_en,
  input  logic [lers_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [lers_pkg::CFG_BITS-1:0]       cfg_wr_data
);
  import lers_pkg::*;

  lers_cfg_t    cfg;
  lers_center_t center;
  lers_event_t  push_data;
  lers_event_t  pop_data;
  lers_result_t res_data;
  logic         ev_push;
  logic         ev_full;
  logic         ev_pop;
  logic         ev_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width    <= RST_FRAME_WIDTH;
      cfg.frame_height   <= RST_FRAME_HEIGHT;
      cfg.band_first_row <= RST_BAND_FIRST_ROW;
      cfg.band_end_row   <= RST_BAND_END_ROW;
      cfg.min_edge_rows  <= RST_MIN_EDGE_ROWS;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:    cfg.frame_width    <= cfg_wr_data;
        CFG_FRAME_HEIGHT:   cfg.frame_height   <= cfg_wr_data;
        CFG_BAND_FIRST_ROW: cfg.band_first_row <= cfg_wr_data[FIELD_COL_BITS-1:0];
        CFG_BAND_END_ROW:   cfg.band_end_row   <= cfg_wr_data;
        CFG_MIN_EDGE_ROWS:  cfg.min_edge_rows  <= cfg_wr_data;
        default: begin
        end
      endcase
    end
  end

  lers_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .center      (center),
    .pix_valid   (s_axis_tvalid),
    .pix_ready   (s_axis_tready),
    .pixel_on    (s_axis_tdata[0]),
    .frame_begin (s_axis_tuser),
    .ev_push     (ev_push),
    .ev_data     (push_data),
    .ev_full     (ev_full)
  );

  lers_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (ev_push),
    .push_data (push_data),
    .full      (ev_full),
    .pop       (ev_pop),
    .pop_data  (pop_data),
    .empty     (ev_empty)
  );

  lers_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .ev_empty  (ev_empty),
    .ev_pop    (ev_pop),
    .ev_data   (pop_data),
    .center    (center),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res_data  (res_data),
    .res_kind  (m_axis_tuser),
    .res_last  (m_axis_tlast)
  );

  assign m_axis_tdata = res_data;

endmodule

FILE: src/lers_front.sv
// Pixel front end: column and row counters, edge detection per row.
// Pushes row and frame-end events into the queue; depends on lers_pkg.
`include "assert_macros.svh"

module lers_front (
  input  logic                  clk,
  input  logic                  rst,
  input  lers_pkg::lers_cfg_t   cfg,
  input  lers_pkg::lers_center_t center,
  input  logic                  pix_valid,
  output logic                  pix_ready,
  input  logic                  pixel_on,
  input  logic                  frame_begin,
  output logic                  ev_push,
  output lers_pkg::lers_event_t ev_data,
  input  logic                  ev_full
);
  import lers_pkg::*;

  logic [COL_BITS-1:0]       column_count;
  logic [COL_BITS-1:0]       row_count;
  logic                      previous_pixel;
  logic                      left_valid;
  logic                      right_valid;
  logic [COL_BITS-1:0]       row_left_hit;
  logic [COL_BITS-1:0]       row_right_hit;
  logic [FIELD_CNT_BITS-1:0] frame_left_rows;
  logic [FIELD_CNT_BITS-1:0] frame_right_rows;
  logic                      wait_center;

  logic [DIM_BITS-1:0]       w;
  logic [DIM_BITS-1:0]       h;
  logic [COL_BITS-1:0]       c;
  logic [COL_BITS-1:0]       r;
  logic [COL_BITS-1:0]       c_minus;
  logic [DIM_BITS-1:0]       c_inc;
  logic [DIM_BITS-1:0]       r_inc;
  logic [FIELD_CNT_BITS-1:0] lr_base;
  logic [FIELD_CNT_BITS-1:0] rr_base;
  logic [FIELD_CNT_BITS-1:0] lr_next;
  logic [FIELD_CNT_BITS-1:0] rr_next;
  logic                      left_valid_next;
  logic                      right_valid_next;
  logic [COL_BITS-1:0]       row_left_hit_next;
  logic [COL_BITS-1:0]       row_right_hit_next;
  logic                      row_end;
  logic                      frame_end;
  logic                      in_band;
  logic                      accept;

  assign pix_ready = !wait_center && !ev_full;
  assign accept    = pix_valid && pix_ready;

  assign w       = clamp_dim(cfg.frame_width);
  assign h       = clamp_dim(cfg.frame_height);
  assign c       = frame_begin ? '0 : column_count;
  assign r       = frame_begin ? '0 : row_count;
  assign lr_base = frame_begin ? '0 : frame_left_rows;
  assign rr_base = frame_begin ? '0 : frame_right_rows;
  assign c_minus = c - COL_BITS'(1);
  assign c_inc   = DIM_BITS'(c) + DIM_BITS'(1);
  assign r_inc   = DIM_BITS'(r) + DIM_BITS'(1);

  assign row_end   = (c_inc >= w);
  assign frame_end = row_end && (r_inc >= h);
  assign in_band   = (32'(r) >= 32'(cfg.band_first_row)) && (32'(r) < 32'(cfg.band_end_row));

  always_comb begin
    left_valid_next    = left_valid;
    right_valid_next   = right_valid;
    row_left_hit_next  = row_left_hit;
    row_right_hit_next = row_right_hit;
    if (c == '0) begin
      left_valid_next    = 1'b0;
      right_valid_next   = 1'b0;
      row_left_hit_next  = '0;
      row_right_hit_next = '0;
    end else begin
      if (previous_pixel && !pixel_on && (c <= center.col)) begin
        left_valid_next   = 1'b1;
        row_left_hit_next = c;
      end
      if (!previous_pixel && pixel_on && (c_minus >= center.col) && !right_valid) begin
        right_valid_next   = 1'b1;
        row_right_hit_next = c_minus;
      end
    end
  end

  always_comb begin
    lr_next = lr_base;
    rr_next = rr_base;
    if (row_end && in_band) begin
      if (left_valid_next && (lr_base != CNT_MAX)) begin
        lr_next = lr_base + FIELD_CNT_BITS'(1);
      end
      if (right_valid_next && (rr_base != CNT_MAX)) begin
        rr_next = rr_base + FIELD_CNT_BITS'(1);
      end
    end
  end

  assign ev_push = accept && row_end && (in_band || frame_end);

  always_comb begin
    ev_data             = '0;
    ev_data.has_row     = in_band;
    ev_data.frame_end   = frame_end;
    ev_data.row_index   = r;
    ev_data.left_found  = left_valid_next;
    ev_data.left_col    = row_left_hit_next;
    ev_data.right_found = right_valid_next;
    ev_data.right_col   = row_right_hit_next;
    ev_data.left_rows   = lr_next;
    ev_data.right_rows  = rr_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count     <= '0;
      row_count        <= '0;
      previous_pixel   <= 1'b0;
      left_valid       <= 1'b0;
      right_valid      <= 1'b0;
      row_left_hit     <= '0;
      row_right_hit    <= '0;
      frame_left_rows  <= '0;
      frame_right_rows <= '0;
      wait_center      <= 1'b0;
    end else begin
      if (center.update) begin
        wait_center <= 1'b0;
      end
      if (accept) begin
        previous_pixel <= pixel_on;
        left_valid     <= left_valid_next;
        right_valid    <= right_valid_next;
        row_left_hit   <= row_left_hit_next;
        row_right_hit  <= row_right_hit_next;
        column_count   <= row_end ? '0 : c_inc[COL_BITS-1:0];
        if (!row_end) begin
          row_count <= r;
        end else if (frame_end) begin
          row_count <= '0;
        end else begin
          row_count <= r_inc[COL_BITS-1:0];
        end
        frame_left_rows  <= frame_end ? '0 : lr_next;
        frame_right_rows <= frame_end ? '0 : rr_next;
        if (frame_end) begin
          wait_center <= 1'b1;
        end
      end
    end
  end

  `ASSERT_IMPLIES(a_push_not_full, ev_push, !ev_full, "event pushed into full queue")
  `ASSERT_NEXT(a_frame_end_waits, ev_push && ev_data.frame_end, wait_center, "no stall after frame end")

endmodule

FILE: src/lers_queue.sv
// Short event queue between the pixel front end and the result back end.
// Holds lers_pkg::lers_event_t entries; depends on lers_pkg.
module lers_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  lers_pkg::lers_event_t push_data,
  output logic                  full,
  input  logic                  pop,
  output lers_pkg::lers_event_t pop_data,
  output logic                  empty
);
  import lers_pkg::*;

  lers_event_t                entries [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0]   wr_ptr;
  logic [FIFO_PTR_BITS-1:0]   rd_ptr;
  logic [FIFO_CNT_BITS-1:0]   count;
  logic                       do_push;
  logic                       do_pop;

  assign full     = (count == FIFO_CNT_BITS'(FIFO_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + FIFO_CNT_BITS'(1);
      end else if (!do_push && do_pop) begin
        count <= count - FIFO_CNT_BITS'(1);
      end
    end
  end

endmodule

FILE: src/lers_back.sv
// Result back end: row results, running totals, frame summary and the
// shift-subtract divider for the next center. Depends on lers_pkg.
`include "assert_macros.svh"

module lers_back (
  input  logic                   clk,
  input  logic                   rst,
  input  lers_pkg::lers_cfg_t    cfg,
  input  logic                   ev_empty,
  output logic                   ev_pop,
  input  lers_pkg::lers_event_t  ev_data,
  output lers_pkg::lers_center_t center,
  output logic                   res_valid,
  input  logic                   res_ready,
  output lers_pkg::lers_result_t res_data,
  output logic                   res_kind,
  output logic                   res_last
);
  import lers_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_MUL,
    ST_DIV,
    ST_FIX,
    ST_SUM
  } state_t;

  state_t                    state;
  lers_event_t               ev;
  logic [TOTAL_BITS-1:0]     left_total;
  logic [TOTAL_BITS-1:0]     right_total;
  logic [COL_BITS-1:0]       search_center;
  logic                      center_update;
  logic [REM_BITS-1:0]       rem;
  logic [REM_BITS-1:0]       dsh;
  logic [COL_BITS-1:0]       quo;
  logic                      lge;
  logic [DIV_CNT_BITS-1:0]   div_cnt;

  logic [DIM_BITS-1:0]       w;
  logic [COL_BITS-1:0]       base;
  logic [RANGE_BITS-1:0]     rng;
  logic [RANGE10_BITS-1:0]   range10;
  logic [TOTAL_BITS-1:0]     diff;
  logic [DVS_BITS-1:0]       tot_sum;
  logic [DVS_BITS-1:0]       dvs;
  logic [PROD_BITS-1:0]      prod;
  logic                      rem_ge;
  logic                      round_up;
  logic [COL_BITS:0]         q_up;
  logic [COL_BITS:0]         q_lim;
  logic [COL_BITS:0]         base_x;
  logic [COL_BITS:0]         ctr_left;
  logic [COL_BITS:0]         ctr_right;
  logic [COL_BITS-1:0]       new_center;
  logic [MODE_BITS-1:0]      mode;
  lers_result_t              row_res;
  lers_result_t              sum_res;

  assign ev_pop        = (state == ST_IDLE) && !ev_empty;
  assign center.update = center_update;
  assign center.col    = search_center;

  assign w       = clamp_dim(cfg.frame_width);
  assign base    = w[DIM_BITS-1:1];
  assign rng     = w[DIM_BITS-1:2];
  assign range10 = (RANGE10_BITS'(rng) << 3) + (RANGE10_BITS'(rng) << 1);
  assign diff    = (left_total >= right_total) ? (left_total - right_total)
                                               : (right_total - left_total);
  assign tot_sum = DVS_BITS'(left_total) + DVS_BITS'(right_total);
  assign dvs     = (tot_sum << 3) + (tot_sum << 1) + DVS_BITS'(1);
  assign prod    = PROD_BITS'(range10) * PROD_BITS'(diff);
  assign rem_ge  = (rem >= dsh);

  assign round_up  = !lge && (rem != '0);
  assign q_up      = {1'b0, quo} + {{COL_BITS{1'b0}}, round_up};
  assign base_x    = {1'b0, base};
  assign q_lim     = (q_up > base_x) ? base_x : q_up;
  assign ctr_left  = base_x - q_lim;
  assign ctr_right = base_x + {1'b0, quo};
  assign new_center = lge ? ctr_right[COL_BITS-1:0] : ctr_left[COL_BITS-1:0];

  always_comb begin
    priority if ((ev.right_rows > cfg.min_edge_rows) && (ev.left_rows > cfg.min_edge_rows)) begin
      mode = MODE_BOTH;
    end else if ((ev.right_rows >= ev.left_rows) && (ev.right_rows > cfg.min_edge_rows)) begin
      mode = MODE_RIGHT;
    end else if ((ev.left_rows > ev.right_rows) && (ev.left_rows > cfg.min_edge_rows)) begin
      mode = MODE_LEFT;
    end else begin
      mode = MODE_NONE;
    end
  end

  always_comb begin
    row_res             = '0;
    row_res.row_index   = to_field_col(ev_data.row_index);
    row_res.left_found  = ev_data.left_found;
    row_res.left_col    = to_field_col(ev_data.left_col);
    row_res.right_found = ev_data.right_found;
    row_res.right_col   = to_field_col(ev_data.right_col);
    row_res.center_col  = to_field_col(search_center);
    row_res.lane_mode   = MODE_NONE;
    row_res.left_rows   = ev_data.left_rows;
    row_res.right_rows  = ev_data.right_rows;
  end

  always_comb begin
    sum_res            = '0;
    sum_res.row_index  = to_field_col(ev.row_index);
    sum_res.center_col = to_field_col(new_center);
    sum_res.lane_mode  = mode;
    sum_res.left_rows  = ev.left_rows;
    sum_res.right_rows = ev.right_rows;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      left_total    <= TOTAL_BITS'(1);
      right_total   <= TOTAL_BITS'(1);
      search_center <= RST_CENTER;
      center_update <= 1'b0;
      res_valid     <= 1'b0;
      res_kind      <= KIND_ROW;
      res_last      <= 1'b0;
    end else begin
      center_update <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (!ev_empty) begin
            ev <= ev_data;
            if (ev_data.has_row) begin
              if (ev_data.left_found && (left_total != '1)) begin
                left_total <= left_total + TOTAL_BITS'(1);
              end
              if (ev_data.right_found && (right_total != '1)) begin
                right_total <= right_total + TOTAL_BITS'(1);
              end
              res_data  <= row_res;
              res_kind  <= KIND_ROW;
              res_last  <= !ev_data.frame_end;
              res_valid <= 1'b1;
              state     <= ST_ROW;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_ROW: begin
          if (res_ready) begin
            res_valid <= 1'b0;
            state     <= ev.frame_end ? ST_MUL : ST_IDLE;
          end
        end
        ST_MUL: begin
          rem     <= REM_BITS'(prod);
          dsh     <= REM_BITS'(dvs) << (COL_BITS - 1);
          quo     <= '0;
          lge     <= (left_total >= right_total);
          div_cnt <= DIV_CNT_BITS'(COL_BITS - 1);
          state   <= ST_DIV;
        end
        ST_DIV: begin
          if (rem_ge) begin
            rem <= rem - dsh;
          end
          quo <= {quo[COL_BITS-2:0], rem_ge};
          dsh <= dsh >> 1;
          if (div_cnt == '0) begin
            state <= ST_FIX;
          end else begin
            div_cnt <= div_cnt - DIV_CNT_BITS'(1);
          end
        end
        ST_FIX: begin
          search_center <= new_center;
          center_update <= 1'b1;
          res_data      <= sum_res;
          res_kind      <= KIND_SUMMARY;
          res_last      <= 1'b1;
          res_valid     <= 1'b1;
          state         <= ST_SUM;
        end
        ST_SUM: begin
          if (res_ready) begin
            res_valid <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPLIES(a_quo_in_range, state == ST_FIX, 32'(quo) <= 32'(rng), "quotient above range")
  `ASSERT_NEXT(a_fix_gives_summary, state == ST_FIX, res_valid && (res_kind == KIND_SUMMARY), "summary missing")
  `ASSERT_IMPLIES(a_pop_output_free, ev_pop, !res_valid, "pop while result pending")

endmodule
